/* hdl/bst_pkg.sv */
// ---------------------------------------------------------------------------
// bst_pkg
// Shared types and fixed widths for the bounded set table.
// ---------------------------------------------------------------------------
package bst_pkg;

	// widths fixed by the request and result fields
	localparam int REQ_W      = 2;
	localparam int PORT_KEY_W = 32;
	localparam int RANK_W     = 4;
	localparam int COUNT_W    = 5;

	// capacity register value after reset
	localparam logic [COUNT_W-1:0] CAP_RESET = 5'd16;

	// request kinds
	typedef enum logic [REQ_W-1:0] {
		REQ_INSERT   = 2'd0,
		REQ_ERASE    = 2'd1,
		REQ_CONTAINS = 2'd2,
		REQ_GET      = 2'd3
	} req_t;

endpackage

/* hdl/bst_ram.sv */
// ---------------------------------------------------------------------------
// bst_ram
// Simple dual-port key store: one write port, one read port, registered
// read data. Contents are not cleared by reset.
// ---------------------------------------------------------------------------
module bst_ram #(
	parameter int DEPTH  = 16,
	parameter int WIDTH  = 32,
	parameter int ADDR_W = 4
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

/* hdl/bounded_set_table.sv */
// ---------------------------------------------------------------------------
// bounded_set_table
// Set of distinct keys held sorted in a one-port-read RAM; supports insert,
// erase, membership test and get-by-rank.
// ---------------------------------------------------------------------------
// Sequence: done strobes as busy drops, on the return to idle. Get reads one slot.
//   Insert, erase and contains scan from slot 0 up to the first key >= the request
//   key, else to slot count-1 (no scan on an empty set), then decide; an insert or
//   erase then moves each later entry by one slot, and a shifted insert writes last.
// Throughput: one request at a time; a new request is taken in the done cycle.
// Reset: key count 0, capacity 16; the key RAM is not cleared.
// ---------------------------------------------------------------------------
module bounded_set_table #(
	parameter int DEPTH     = 16,
	parameter int KEY_WIDTH = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// request
	input  logic                             start,
	output logic                             busy,
	input  logic [bst_pkg::REQ_W-1:0]        req_type,
	input  logic [bst_pkg::PORT_KEY_W-1:0]   key,
	input  logic [bst_pkg::RANK_W-1:0]       rank_index,
	// result
	output logic                             done,
	output logic                             ok,
	output logic [bst_pkg::PORT_KEY_W-1:0]   item_out,
	output logic [bst_pkg::COUNT_W-1:0]      count,
	// capacity register write
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [bst_pkg::COUNT_W-1:0]      cfg_data
);

	import bst_pkg::*;

	localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int DEPTH_CLIP = (DEPTH > 31) ? 31 : DEPTH;
	localparam logic [COUNT_W-1:0] DEPTH_LIM = COUNT_W'(DEPTH_CLIP);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_SHIFT_UP,
		ST_INS_WR,
		ST_SHIFT_DN,
		ST_GET
	} state_t;

	state_t                 state_q;
	req_t                   op_q;
	logic [KEY_WIDTH-1:0]   key_q;
	logic [RANK_W-1:0]      rank_q;
	logic [COUNT_W-1:0]     idx_q;
	logic [COUNT_W-1:0]     pos_q;
	logic                   eq_q;
	logic [COUNT_W-1:0]     count_q;
	logic [COUNT_W-1:0]     cap_q;
	logic                   done_q;
	logic                   ok_q;
	logic [PORT_KEY_W-1:0]  item_q;

	logic [COUNT_W-1:0]     rd_idx;
	logic [COUNT_W-1:0]     wr_idx;
	logic                   mem_we;
	logic [KEY_WIDTH-1:0]   mem_wdata;
	logic [KEY_WIDTH-1:0]   mem_rdata;
	logic [COUNT_W-1:0]     limit;
	logic                   insert_ok;
	logic [COUNT_W-1:0]     count_m1;

	// effective limit and insert admission
	assign limit     = (cap_q < DEPTH_LIM) ? cap_q : DEPTH_LIM;
	assign insert_ok = !eq_q && (count_q < limit);
	assign count_m1  = count_q - COUNT_W'(1);

	// key store
	bst_ram #(
		.DEPTH  (DEPTH),
		.WIDTH  (KEY_WIDTH),
		.ADDR_W (ADDR_W)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (ADDR_W'(wr_idx)),
		.wdata (mem_wdata),
		.raddr (ADDR_W'(rd_idx)),
		.rdata (mem_rdata)
	);

	// RAM address and write control per state
	always_comb begin
		rd_idx    = idx_q + COUNT_W'(1);
		wr_idx    = idx_q;
		mem_we    = 1'b0;
		mem_wdata = mem_rdata;
		unique case (state_q)
			ST_IDLE: begin
				rd_idx = (req_t'(req_type) == REQ_GET) ? COUNT_W'(rank_index) : '0;
			end
			ST_SCAN: begin
				rd_idx = idx_q + COUNT_W'(1);
			end
			ST_DECIDE: begin
				if (op_q == REQ_INSERT) begin
					rd_idx = count_m1;
					if (insert_ok && pos_q == count_q) begin
						mem_we    = 1'b1;
						wr_idx    = pos_q;
						mem_wdata = key_q;
					end
				end else begin
					rd_idx = pos_q + COUNT_W'(1);
				end
			end
			ST_SHIFT_UP: begin
				mem_we    = 1'b1;
				wr_idx    = idx_q + COUNT_W'(1);
				mem_wdata = mem_rdata;
				rd_idx    = idx_q - COUNT_W'(1);
			end
			ST_INS_WR: begin
				mem_we    = 1'b1;
				wr_idx    = pos_q;
				mem_wdata = key_q;
			end
			ST_SHIFT_DN: begin
				mem_we    = 1'b1;
				wr_idx    = idx_q - COUNT_W'(1);
				mem_wdata = mem_rdata;
				rd_idx    = idx_q + COUNT_W'(1);
			end
			ST_GET: begin
				rd_idx = idx_q;
			end
			default: begin
				rd_idx = idx_q;
			end
		endcase
	end

	// sequencer: scan, shift and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
			ok_q    <= 1'b0;
			item_q  <= '0;
			op_q    <= REQ_INSERT;
			idx_q   <= '0;
			pos_q   <= '0;
			eq_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						op_q   <= req_t'(req_type);
						key_q  <= KEY_WIDTH'(key);
						rank_q <= rank_index;
						idx_q  <= '0;
						if (req_t'(req_type) == REQ_GET) begin
							state_q <= ST_GET;
						end else if (count_q == '0) begin
							pos_q   <= '0;
							eq_q    <= 1'b0;
							state_q <= ST_DECIDE;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				// sorted scan: stop at the first key >= request key
				ST_SCAN: begin
					if (mem_rdata >= key_q) begin
						pos_q   <= idx_q;
						eq_q    <= (mem_rdata == key_q);
						state_q <= ST_DECIDE;
					end else if (idx_q == count_m1) begin
						pos_q   <= count_q;
						eq_q    <= 1'b0;
						state_q <= ST_DECIDE;
					end else begin
						idx_q <= idx_q + COUNT_W'(1);
					end
				end
				ST_DECIDE: begin
					unique case (op_q)
						REQ_INSERT: begin
							if (!insert_ok) begin
								ok_q    <= 1'b0;
								item_q  <= '0;
								done_q  <= 1'b1;
								state_q <= ST_IDLE;
							end else if (pos_q == count_q) begin
								count_q <= count_q + COUNT_W'(1);
								ok_q    <= 1'b1;
								item_q  <= '0;
								done_q  <= 1'b1;
								state_q <= ST_IDLE;
							end else begin
								idx_q   <= count_m1;
								state_q <= ST_SHIFT_UP;
							end
						end
						REQ_ERASE: begin
							if (!eq_q) begin
								ok_q    <= 1'b0;
								item_q  <= '0;
								done_q  <= 1'b1;
								state_q <= ST_IDLE;
							end else if (pos_q == count_m1) begin
								count_q <= count_m1;
								ok_q    <= 1'b1;
								item_q  <= '0;
								done_q  <= 1'b1;
								state_q <= ST_IDLE;
							end else begin
								idx_q   <= pos_q + COUNT_W'(1);
								state_q <= ST_SHIFT_DN;
							end
						end
						default: begin
							ok_q    <= eq_q;
							item_q  <= '0;
							done_q  <= 1'b1;
							state_q <= ST_IDLE;
						end
					endcase
				end
				// move entries up one slot, top first, to open the insert slot
				ST_SHIFT_UP: begin
					if (idx_q == pos_q) begin
						state_q <= ST_INS_WR;
					end else begin
						idx_q <= idx_q - COUNT_W'(1);
					end
				end
				ST_INS_WR: begin
					count_q <= count_q + COUNT_W'(1);
					ok_q    <= 1'b1;
					item_q  <= '0;
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				// move entries down one slot over the erased key
				ST_SHIFT_DN: begin
					if (idx_q == count_m1) begin
						count_q <= count_m1;
						ok_q    <= 1'b1;
						item_q  <= '0;
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						idx_q <= idx_q + COUNT_W'(1);
					end
				end
				// sorted store: rank r sits in slot r
				ST_GET: begin
					if (COUNT_W'(rank_q) < count_q) begin
						ok_q   <= 1'b1;
						item_q <= PORT_KEY_W'(mem_rdata);
					end else begin
						ok_q   <= 1'b0;
						item_q <= '0;
					end
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			cap_q <= cfg_data;
		end
	end

	assign cfg_ready = 1'b1;
	assign busy      = (state_q != ST_IDLE);
	assign done      = done_q;
	assign ok        = ok_q;
	assign item_out  = item_q;
	assign count     = count_q;

	// checks
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without a request in flight");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_W'(DEPTH_CLIP))
		else $error("key count above table depth");

	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && ok && op_q == REQ_INSERT) |-> (count_q == $past(count_q) + COUNT_W'(1)))
		else $error("successful insert did not grow the count");

	a_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> busy)
		else $error("RAM write while idle");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted request did not start");

endmodule

/* tb/tb_bounded_set_table.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_bounded_set_table
// Self-checking bench for the bounded set table. A shadow copy of the set
// predicts ok, item_out and count for every accepted request; results are
// checked in order as they strobe out. Directed cases cover the empty set,
// key extremes, duplicates, absent keys, out-of-range ranks and capacity
// limits, followed by random request mixes under several capacity settings
// and sender gap rates.
// ---------------------------------------------------------------------------
module tb_bounded_set_table;
	import bst_pkg::*;

	localparam int DEPTH        = 16;
	localparam int KEY_W        = 32;
	localparam int POOL_SIZE    = 24;
	localparam int DRAIN_CYCLES = 2 * DEPTH + 8;
	localparam int BLOCK_ITEMS  = 100;
	localparam int PHASE_ITEMS  = 500;

	typedef struct packed {
		logic                  ok;
		logic [PORT_KEY_W-1:0] item;
		logic [COUNT_W-1:0]    cnt;
	} set_result_t;

	logic                  clk        = 1'b0;
	logic                  arst_n     = 1'b0;
	logic                  start      = 1'b0;
	logic                  busy;
	logic [REQ_W-1:0]      req_type   = '0;
	logic [PORT_KEY_W-1:0] key        = '0;
	logic [RANK_W-1:0]     rank_index = '0;
	logic                  done;
	logic                  ok;
	logic [PORT_KEY_W-1:0] item_out;
	logic [COUNT_W-1:0]    count;
	logic                  cfg_valid  = 1'b0;
	logic                  cfg_ready;
	logic [COUNT_W-1:0]    cfg_data   = '0;

	// shadow copy of the set and the capacity register
	logic [PORT_KEY_W-1:0] held_keys [DEPTH];
	int unsigned           held_n     = 0;
	int unsigned           cap_shadow = 32'(CAP_RESET);

	set_result_t           pending_results [$];
	int unsigned           mismatch_count  = 0;
	int unsigned           sender_idle_pct = 0;
	logic [PORT_KEY_W-1:0] key_pool [POOL_SIZE];

	bounded_set_table #(
		.DEPTH     (DEPTH),
		.KEY_WIDTH (KEY_W)
	) DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.req_type   (req_type),
		.key        (key),
		.rank_index (rank_index),
		.done       (done),
		.ok         (ok),
		.item_out   (item_out),
		.count      (count),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data)
	);

	always #1 clk = ~clk;

	// hard stop in case the block hangs
	initial begin
		#2_000_000;
		$display("Some tests failed");
		$finish;
	end

	task automatic report_mismatch(string what, logic [PORT_KEY_W-1:0] want,
			logic [PORT_KEY_W-1:0] got);
		if (mismatch_count < 100)
			$display("%0t: %s mismatch: wanted %h, got %h", $time, what, want, got);
		mismatch_count++;
	endtask

	function automatic int find_held(logic [PORT_KEY_W-1:0] k);
		int s;
		for (s = 0; s < held_n; s++)
			if (held_keys[s] == k)
				return s;
		return -1;
	endfunction

	// update the shadow set with one request and return the result it gives
	function automatic set_result_t apply_set_request(req_t kind,
			logic [PORT_KEY_W-1:0] k, logic [RANK_W-1:0] rank);
		set_result_t r;
		int          slot;
		int          s;
		int          t;
		int unsigned limit;
		int unsigned below;
		r     = '0;
		limit = (cap_shadow < DEPTH) ? cap_shadow : DEPTH;
		case (kind)
			REQ_INSERT: begin
				if (held_n < limit && find_held(k) < 0) begin
					held_keys[held_n] = k;
					held_n++;
					r.ok = 1'b1;
				end
			end
			REQ_ERASE: begin
				slot = find_held(k);
				if (slot >= 0) begin
					for (s = slot; s + 1 < held_n; s++)
						held_keys[s] = held_keys[s + 1];
					held_n--;
					r.ok = 1'b1;
				end
			end
			REQ_CONTAINS: begin
				r.ok = (find_held(k) >= 0);
			end
			default: begin
				// rank = number of held keys strictly below it
				if (rank < held_n) begin
					r.ok = 1'b1;
					for (s = 0; s < held_n; s++) begin
						below = 0;
						for (t = 0; t < held_n; t++)
							if (held_keys[s] > held_keys[t])
								below++;
						if (below == rank)
							r.item = held_keys[s];
					end
				end
			end
		endcase
		r.cnt = COUNT_W'(held_n);
		return r;
	endfunction

	// one request transfer; start stays high afterwards so back-to-back items
	// need no extra assignment in the same step
	task automatic send_req(req_t kind, logic [PORT_KEY_W-1:0] k, logic [RANK_W-1:0] rank);
		int   gap;
		logic was_busy;
		gap = 0;
		while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct && gap < 40)
			gap++;
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start      <= 1'b1;
		req_type   <= kind;
		key        <= k;
		rank_index <= rank;
		do begin
			@(negedge clk);
			was_busy = busy;
			@(posedge clk);
		end while (was_busy);
		pending_results.push_back(apply_set_request(kind, k, rank));
	endtask

	// drop start and wait until every result is back
	task automatic settle();
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// capacity register transfer; only called with the block idle
	task automatic write_capacity(logic [COUNT_W-1:0] v);
		logic rdy;
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do begin
			@(negedge clk);
			rdy = cfg_ready;
			@(posedge clk);
		end while (!rdy);
		cfg_valid  <= 1'b0;
		cap_shadow  = 32'(v);
	endtask

	// results are sampled mid-cycle, away from the driving edge
	always @(negedge clk) begin
		set_result_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unrequested result", '0, item_out);
			end else begin
				want = pending_results.pop_front();
				if (ok !== want.ok)
					report_mismatch("ok", PORT_KEY_W'(want.ok), PORT_KEY_W'(ok));
				if (item_out !== want.item)
					report_mismatch("item_out", want.item, item_out);
				if (count !== want.cnt)
					report_mismatch("count", PORT_KEY_W'(want.cnt), PORT_KEY_W'(count));
			end
		end
	end

	// get, contains and erase on a freshly reset set
	task automatic test_empty_set();
		send_req(REQ_GET, 32'h0, 4'd0);
		send_req(REQ_CONTAINS, 32'h0, 4'd0);
		send_req(REQ_ERASE, 32'h5, 4'd0);
	endtask

	// extreme keys, duplicate insert, ranks in and out of range, absent erase
	task automatic test_key_extremes();
		send_req(REQ_INSERT, 32'h0, 4'd0);
		send_req(REQ_INSERT, 32'hFFFF_FFFF, 4'd15);
		send_req(REQ_INSERT, 32'hFFFF_FFFF, 4'd0);
		send_req(REQ_CONTAINS, 32'hFFFF_FFFF, 4'd0);
		send_req(REQ_GET, 32'hFFFF_FFFF, 4'd0);
		send_req(REQ_GET, 32'h0, 4'd1);
		send_req(REQ_GET, 32'h0, 4'd2);
		send_req(REQ_GET, 32'h0, 4'd15);
		send_req(REQ_ERASE, 32'h0, 4'd0);
		send_req(REQ_ERASE, 32'h0, 4'd0);
		send_req(REQ_CONTAINS, 32'h0, 4'd0);
	endtask

	// zero capacity, a full set, capacity lowered below the count, max setting
	task automatic test_capacity_limits();
		settle();
		write_capacity(5'd0);
		send_req(REQ_INSERT, 32'h7, 4'd0);
		settle();
		write_capacity(5'd2);
		send_req(REQ_INSERT, 32'h7, 4'd0);
		send_req(REQ_INSERT, 32'h9, 4'd0);
		settle();
		write_capacity(5'd1);
		send_req(REQ_INSERT, 32'hB, 4'd0);
		send_req(REQ_CONTAINS, 32'h7, 4'd0);
		settle();
		write_capacity(5'd31);
		send_req(REQ_INSERT, 32'hB, 4'd0);
	endtask

	function automatic logic [COUNT_W-1:0] pick_capacity();
		case ($urandom_range(9))
			0:       return 5'd0;
			1:       return 5'd1;
			2:       return 5'd31;
			3:       return 5'd16;
			4, 5:    return COUNT_W'($urandom_range(15, 2));
			default: return COUNT_W'($urandom_range(31, 16));
		endcase
	endfunction

	// mostly pool keys so hits and a full set are common; some fully random
	task automatic send_random_req(int unsigned insert_pct);
		req_t                  kind;
		logic [PORT_KEY_W-1:0] k;
		logic [RANK_W-1:0]     rank;
		if ($urandom_range(99) < insert_pct) begin
			kind = REQ_INSERT;
		end else begin
			case ($urandom_range(2))
				0:       kind = REQ_ERASE;
				1:       kind = REQ_CONTAINS;
				default: kind = REQ_GET;
			endcase
		end
		if (kind != REQ_INSERT && held_n != 0 && $urandom_range(9) < 5)
			k = held_keys[$urandom_range(held_n - 1)];
		else if ($urandom_range(99) < 85)
			k = key_pool[$urandom_range(POOL_SIZE - 1)];
		else
			k = $urandom;
		if (held_n != 0 && $urandom_range(3) != 0)
			rank = RANK_W'($urandom_range(held_n - 1));
		else
			rank = RANK_W'($urandom_range(15));
		send_req(kind, k, rank);
	endtask

	// random blocks, each under a fresh capacity and request mix
	task automatic test_random_phase(int unsigned idle_pct);
		int          b;
		int          i;
		int unsigned insert_pct;
		sender_idle_pct = idle_pct;
		for (b = 0; b < PHASE_ITEMS / BLOCK_ITEMS; b++) begin
			settle();
			write_capacity(pick_capacity());
			insert_pct = $urandom_range(60, 20);
			for (i = 0; i < BLOCK_ITEMS; i++)
				send_random_req(insert_pct);
		end
	endtask

	initial begin
		int p;
		key_pool[0] = 32'h0000_0000;
		key_pool[1] = 32'hFFFF_FFFF;
		key_pool[2] = 32'h0000_0001;
		key_pool[3] = 32'h8000_0000;
		key_pool[4] = 32'h7FFF_FFFF;
		key_pool[5] = 32'hFFFF_FFFE;
		for (p = 6; p < POOL_SIZE; p++)
			key_pool[p] = $urandom;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		sender_idle_pct = 35;
		test_empty_set();
		test_key_extremes();
		test_capacity_limits();
		test_random_phase(35);
		test_random_phase(84);
		test_random_phase(0);

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

/* sim.f */
hdl/bst_pkg.sv
hdl/bst_ram.sv
hdl/bounded_set_table.sv
tb/tb_bounded_set_table.sv
